/* sv/assert_macros.svh */
// Assertion macros shared by the sorter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CHK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CHK(label, !(cond), msg)

`endif

/* sv/iss_pkg.sv */
// Package with the shared types and constants of the insertion sorter.
package iss_pkg;

  localparam int unsigned MAX_ELEMS = 32;
  localparam int unsigned DATA_W    = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_e;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;
    logic drain;
  } cell_ctrl_t;

  // Status the chain reports to the controller.
  typedef struct packed {
    logic full;
    logic head_last;
  } chain_stat_t;

endpackage

/* sv/iss_cell.sv */
// One slot of the sorted chain: compares, shifts up on insert, shifts down on drain.
module iss_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  iss_pkg::cell_ctrl_t ctrl_i,
  input  iss_pkg::data_t      new_val_i,
  input  iss_pkg::data_t      lower_val_i,
  input  logic                lower_valid_i,
  input  logic                lower_gt_i,
  input  iss_pkg::data_t      upper_val_i,
  input  logic                upper_valid_i,
  output iss_pkg::data_t      val_o,
  output logic                valid_o,
  output logic                gt_o
);

  iss_pkg::data_t val_q, val_d;
  logic           valid_q, valid_d;
  logic           gt;

  // An empty slot counts as holding something larger than any value.
  assign gt = !valid_q || (new_val_i < val_q);

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    if (ctrl_i.drain) begin
      val_d   = upper_val_i;
      valid_d = upper_valid_i;
    end else if (ctrl_i.insert && gt) begin
      // take the neighbor's entry if it moves up too, else the new value lands here
      val_d   = lower_gt_i ? lower_val_i : new_val_i;
      valid_d = lower_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o   = val_q;
  assign valid_o = valid_q;
  assign gt_o    = gt;

endmodule

/* sv/iss_chain.sv */
// Row of sorter cells linked to their neighbors in both directions.
`include "assert_macros.svh"

module iss_chain (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  iss_pkg::cell_ctrl_t  ctrl_i,
  input  iss_pkg::data_t       new_val_i,
  output iss_pkg::data_t       head_val_o,
  output iss_pkg::chain_stat_t stat_o
);

  iss_pkg::data_t                 val_w   [iss_pkg::MAX_ELEMS];
  logic [iss_pkg::MAX_ELEMS-1:0]  valid_w;
  logic [iss_pkg::MAX_ELEMS-1:0]  gt_w;

  for (genvar i = 0; i < iss_pkg::MAX_ELEMS; i++) begin : g_cell
    iss_pkg::data_t lower_val, upper_val;
    logic           lower_valid, lower_gt, upper_valid;

    if (i == 0) begin : g_bottom
      // below the first slot sits an always-valid entry that never moves
      assign lower_val   = new_val_i;
      assign lower_valid = 1'b1;
      assign lower_gt    = 1'b0;
    end else begin : g_lower
      assign lower_val   = val_w[i-1];
      assign lower_valid = valid_w[i-1];
      assign lower_gt    = gt_w[i-1];
    end

    if (i == iss_pkg::MAX_ELEMS - 1) begin : g_top
      assign upper_val   = val_w[i];
      assign upper_valid = 1'b0;
    end else begin : g_upper
      assign upper_val   = val_w[i+1];
      assign upper_valid = valid_w[i+1];
    end

    iss_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl_i),
      .new_val_i     (new_val_i),
      .lower_val_i   (lower_val),
      .lower_valid_i (lower_valid),
      .lower_gt_i    (lower_gt),
      .upper_val_i   (upper_val),
      .upper_valid_i (upper_valid),
      .val_o         (val_w[i]),
      .valid_o       (valid_w[i]),
      .gt_o          (gt_w[i])
    );
  end

  assign head_val_o       = val_w[0];
  assign stat_o.full      = valid_w[iss_pkg::MAX_ELEMS-1];
  assign stat_o.head_last = !valid_w[1];

  // occupied slots always form a contiguous run from the bottom
  `ASSERT_CHK(a_valid_thermo, ((valid_w + 1'b1) & valid_w) == '0, "chain occupancy has a hole")
  `ASSERT_NEVER(a_ctrl_excl, ctrl_i.insert && ctrl_i.drain, "insert and drain in one cycle")
  `ASSERT_CHK(a_full_hold, ctrl_i.insert |-> !stat_o.full, "insert into a full chain")

endmodule

/* sv/insertion_sorter_unit.sv */
// Top level of the insertion sorter: handshake control, drop flag and cell chain.
//
//  port group        dir  payload                                  handshake
//  input item        in   value_i, end_of_set_i                    start / busy
//  result item       out  sorted_value_o, final_item_o,            result_valid_o strobe
//                         overflowed_o
//
// Each accepted input is inserted into the chain, or dropped if it is full, so items
// stream in back to back while loading. After the end_of_set_i transaction, busy is
// high and the chain drains one stored value per cycle by shifting down, giving one
// result for each stored value (at most MAX_ELEMS).
// Reset empties the chain and clears the drop flag; the slot values stay unknown.
// Results cannot be stalled; result_valid_o stays high through the whole drain.
`include "assert_macros.svh"

module insertion_sorter_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [31:0]   value_i,
  input  logic                 end_of_set_i,
  output logic                 result_valid_o,
  output logic signed [31:0]   sorted_value_o,
  output logic                 final_item_o,
  output logic                 overflowed_o
);

  iss_pkg::state_e      state_q, state_d;
  logic                 drop_q, drop_d;
  logic                 accept;
  iss_pkg::cell_ctrl_t  ctrl;
  iss_pkg::chain_stat_t stat;
  iss_pkg::data_t       head_val;

  assign busy   = (state_q == iss_pkg::ST_DRAIN);
  assign accept = start && !busy;

  always_comb begin
    state_d     = state_q;
    drop_d      = drop_q;
    ctrl.insert = 1'b0;
    ctrl.drain  = 1'b0;
    case (state_q)
      iss_pkg::ST_LOAD: begin
        if (accept) begin
          ctrl.insert = !stat.full;
          // drop the value when every slot is taken
          if (stat.full) begin
            drop_d = 1'b1;
          end
          if (end_of_set_i) begin
            state_d = iss_pkg::ST_DRAIN;
          end
        end
      end
      iss_pkg::ST_DRAIN: begin
        ctrl.drain = 1'b1;
        if (stat.head_last) begin
          drop_d  = 1'b0;
          state_d = iss_pkg::ST_LOAD;
        end
      end
      default: begin
        state_d = iss_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= iss_pkg::ST_LOAD;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      drop_q  <= drop_d;
    end
  end

  iss_chain u_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .new_val_i  (value_i),
    .head_val_o (head_val),
    .stat_o     (stat)
  );

  assign result_valid_o = (state_q == iss_pkg::ST_DRAIN);
  assign sorted_value_o = head_val;
  assign final_item_o   = result_valid_o && stat.head_last;
  assign overflowed_o   = final_item_o && drop_q;

  `ASSERT_CHK(a_final_ends, final_item_o |=> !busy, "drain continues past final result")
  `ASSERT_CHK(a_drain_run, result_valid_o && !final_item_o |=> result_valid_o,
              "gap inside a drain")
  `ASSERT_CHK(a_last_drains, accept && end_of_set_i |=> result_valid_o,
              "end of set did not start the drain")
  `ASSERT_CHK(a_ovf_final, overflowed_o |-> final_item_o, "overflow flag off the final result")

endmodule
